// File: sv/greedy_capacity_balanced_partition_top_assert.svh
// Assertion helpers for the partition block.
`ifndef GREEDY_CAPACITY_BALANCED_PARTITION_TOP_ASSERT_SVH
`define GREEDY_CAPACITY_BALANCED_PARTITION_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define GCBP_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gcbp check failed");

// Next-cycle implication, masked while reset is asserted.
`define GCBP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gcbp check failed");

`endif

// File: sv/gcbp_pkg.sv
package gcbp_pkg;

    localparam int CFG_W        = 5;
    localparam int BUCKET_IDX_W = 4;
    localparam int SQ_W         = 41;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CAP,
        S_SCAN,
        S_UPDATE,
        S_SQ,
        S_EMIT,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic load;      // store the incoming word
        logic start;     // last word taken: latch bucket count
        logic cap_step;
        logic scan_init;
        logic scan_step;
        logic update;
        logic sq_step;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic cap_done;
        logic scan_end;
        logic assign_end;
        logic sq_done;
        logic out_done;
    } sts_t;

endpackage

// File: sv/gcbp_ctrl.sv
module gcbp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    input  gcbp_pkg::sts_t  sts,
    output gcbp_pkg::cmd_t  cmd
);
    import gcbp_pkg::*;

    state_t state_reg, state_next;
    logic   in_fire;

    assign s_tready = (state_reg == S_LOAD);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:   if (in_fire && s_tlast) state_next = S_CAP;
            S_CAP:    if (sts.cap_done) state_next = S_SCAN;
            S_SCAN:   if (sts.scan_end) state_next = S_UPDATE;
            S_UPDATE: state_next = sts.assign_end ? S_SQ : S_SCAN;
            S_SQ:     if (sts.sq_done) state_next = S_EMIT;
            S_EMIT:   if (sts.out_done) state_next = S_CLEAR;
            S_CLEAR:  state_next = S_LOAD;
            default:  state_next = S_LOAD;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            S_LOAD: begin
                cmd.load  = in_fire;
                cmd.start = in_fire && s_tlast;
            end
            S_CAP: begin
                cmd.cap_step  = 1'b1;
                cmd.scan_init = sts.cap_done;
            end
            S_SCAN:   cmd.scan_step = 1'b1;
            S_UPDATE: cmd.update = 1'b1;
            S_SQ:     cmd.sq_step = 1'b1;
            S_EMIT:   cmd.emit = 1'b1;
            S_CLEAR:  cmd.clear = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

// File: sv/gcbp_dp.sv
module gcbp_dp #(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_BUCKETS  = 16,
    parameter int VALUE_BITS   = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [gcbp_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [VALUE_BITS-1:0]        in_value,
    input  gcbp_pkg::cmd_t               cmd,
    output gcbp_pkg::sts_t               sts,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic                         m_tlast,
    output logic [VALUE_BITS-1:0]        out_value,
    output logic [gcbp_pkg::BUCKET_IDX_W-1:0] out_bucket,
    output logic [gcbp_pkg::SQ_W-1:0]    out_sq,
    output logic                         out_ovf
);
    import gcbp_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int PW = $clog2(MAX_ELEMENTS);
    localparam int KW = $clog2(MAX_BUCKETS + 1);
    localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int TW = VALUE_BITS + CW;

    logic [CFG_W-1:0]             nb_reg;
    logic signed [VALUE_BITS-1:0] sorted_reg [MAX_ELEMENTS];
    logic signed [VALUE_BITS-1:0] ins_next   [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]      keep;
    logic [IW-1:0]                slot_reg   [MAX_ELEMENTS];
    logic signed [TW-1:0]         total_reg  [MAX_BUCKETS];
    logic [CW-1:0]                fill_reg   [MAX_BUCKETS];
    logic [CW-1:0]                count_reg;
    logic                         ovf_reg;
    logic [KW-1:0]                k_reg, k_next;
    logic [CW-1:0]                cap_reg;
    logic [CW+KW-1:0]             cap_acc_reg;
    logic [KW-1:0]                b_reg;
    logic [IW-1:0]                best_reg;
    logic signed [TW-1:0]         best_total_reg;
    logic                         found_reg;
    logic [PW-1:0]                i_reg;
    logic [KW-1:0]                sq_b_reg;
    logic [2*TW-1:0]              sq_prod_reg;
    logic [SQ_W-1:0]              sq_acc_reg;
    logic [CW-1:0]                emit_i_reg;
    logic signed [VALUE_BITS-1:0] v;
    logic                         cand, better, out_room, out_load, out_fire;

    assign v = in_value;

    always_comb begin
        if (nb_reg == '0) begin
            k_next = KW'(1);
        end else if (int'(nb_reg) > MAX_BUCKETS) begin
            k_next = KW'(MAX_BUCKETS);
        end else begin
            k_next = KW'(nb_reg);
        end
    end

    // insert the new word into the descending list in one step
    always_comb begin
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            keep[j] = (CW'(j) < count_reg) && (sorted_reg[j] >= v);
        end
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            if (keep[j]) begin
                ins_next[j] = sorted_reg[j];
            end else if (j == 0) begin
                ins_next[j] = v;
            end else if (keep[j-1]) begin
                ins_next[j] = v;
            end else begin
                ins_next[j] = sorted_reg[j-1];
            end
        end
    end

    assign cand   = fill_reg[b_reg[IW-1:0]] < cap_reg;
    assign better = !found_reg || (total_reg[b_reg[IW-1:0]] < best_total_reg);

    assign sts.cap_done   = cap_acc_reg >= (CW+KW)'(count_reg);
    assign sts.scan_end   = (b_reg == k_reg - KW'(1));
    assign sts.assign_end = (CW'(i_reg) == count_reg - CW'(1));
    assign sts.sq_done    = (sq_b_reg == k_reg);
    assign sts.out_done   = m_tvalid && m_tready && m_tlast;

    assign out_room = !m_tvalid || m_tready;
    assign out_load = cmd.emit && out_room && (emit_i_reg < count_reg);
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            nb_reg <= cfg_wdata;
        end
    end

    // set bookkeeping and bucket state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            for (int b = 0; b < MAX_BUCKETS; b++) begin
                total_reg[b] <= '0;
                fill_reg[b]  <= '0;
            end
        end else begin
            if (cmd.load) begin
                if (count_reg == CW'(MAX_ELEMENTS)) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.update) begin
                total_reg[best_reg] <= total_reg[best_reg]
                                       + TW'(sorted_reg[i_reg]);
                fill_reg[best_reg]  <= fill_reg[best_reg] + CW'(1);
                i_reg               <= i_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && count_reg != CW'(MAX_ELEMENTS)) begin
            for (int j = 0; j < MAX_ELEMENTS; j++) begin
                if (CW'(j) <= count_reg) begin
                    sorted_reg[j] <= ins_next[j];
                end
            end
        end
        if (cmd.update) begin
            slot_reg[i_reg] <= best_reg;
        end
    end

    // cap = ceil(n/k) by repeated add of k
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            k_reg       <= k_next;
            cap_reg     <= '0;
            cap_acc_reg <= '0;
        end else if (cmd.cap_step && !sts.cap_done) begin
            cap_reg     <= cap_reg + CW'(1);
            cap_acc_reg <= cap_acc_reg + (CW+KW)'(k_reg);
        end
    end

    // one bucket per cycle: pick lowest total among buckets with room
    always_ff @(posedge aclk) begin
        if (cmd.scan_init || cmd.update) begin
            b_reg     <= '0;
            found_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            b_reg <= b_reg + KW'(1);
            if (cand && better) begin
                best_reg       <= b_reg[IW-1:0];
                best_total_reg <= total_reg[b_reg[IW-1:0]];
                found_reg      <= 1'b1;
            end
        end
    end

    // square one bucket total per cycle, accumulate the product in the cycle after
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            sq_b_reg    <= '0;
            sq_prod_reg <= '0;
            sq_acc_reg  <= '0;
            emit_i_reg  <= '0;
        end else begin
            if (cmd.sq_step) begin
                sq_acc_reg <= sq_acc_reg + SQ_W'(sq_prod_reg);
                if (!sts.sq_done) begin
                    sq_b_reg    <= sq_b_reg + KW'(1);
                    sq_prod_reg <= (2*TW)'(total_reg[sq_b_reg[IW-1:0]]
                                           * total_reg[sq_b_reg[IW-1:0]]);
                end else begin
                    sq_prod_reg <= '0;
                end
            end
            if (out_load) begin
                emit_i_reg <= emit_i_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_load) begin
            m_tvalid <= 1'b1;
        end else if (out_fire) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value  <= sorted_reg[emit_i_reg[PW-1:0]];
            out_bucket <= BUCKET_IDX_W'(slot_reg[emit_i_reg[PW-1:0]]);
            m_tlast    <= (emit_i_reg == count_reg - CW'(1));
            out_sq     <= (emit_i_reg == count_reg - CW'(1)) ? sq_acc_reg : '0;
            out_ovf    <= ovf_reg;
        end
    end

endmodule

// File: sv/greedy_capacity_balanced_partition_top.sv
// Loading takes one word per cycle; the last word starts processing.
// Processing then finds the bucket size by repeated addition, runs the one-bucket-per-cycle
// selection scan once per element, and squares and sums the bucket totals.
// Results then leave at one word per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties the set and sets the bucket count to 1.
module greedy_capacity_balanced_partition_top #(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_BUCKETS  = 16,
    parameter int VALUE_BITS   = 16,
    parameter int S_DW = ((VALUE_BITS + 7) / 8) * 8,
    parameter int M_DW = ((VALUE_BITS + 4 + 41 + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [gcbp_pkg::CFG_W-1:0] cfg_wdata,   // num_buckets
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [S_DW-1:0]            s_tdata,     // element_value
    input  logic                       s_tlast,     // last_element
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [M_DW-1:0]            m_tdata,     // sorted_value, bucket_index, sum_of_squares
    output logic                       m_tlast,     // last_result
    output logic                       m_tuser      // overflow
);
    import gcbp_pkg::*;

`include "greedy_capacity_balanced_partition_top_assert.svh"

    cmd_t                    cmd;
    sts_t                    sts;
    logic [VALUE_BITS-1:0]   out_value;
    logic [BUCKET_IDX_W-1:0] out_bucket;
    logic [SQ_W-1:0]         out_sq;

    gcbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gcbp_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_BUCKETS  (MAX_BUCKETS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_value   (s_tdata[VALUE_BITS-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tlast    (m_tlast),
        .out_value  (out_value),
        .out_bucket (out_bucket),
        .out_sq     (out_sq),
        .out_ovf    (m_tuser)
    );

    assign m_tdata = M_DW'({out_sq, out_bucket, out_value});

    `GCBP_ASSERT_NOW(a_no_load_while_emit, aclk, aresetn, m_tvalid, !s_tready)
    `GCBP_ASSERT_NOW(a_sq_only_on_last, aclk, aresetn, m_tvalid && !m_tlast,
                     out_sq == '0)
    `GCBP_ASSERT_NEXT(a_clear_after_last, aclk, aresetn,
                      m_tvalid && m_tready && m_tlast, !s_tready && !m_tvalid)

endmodule
